@@ src/minstk_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// minstk_pkg
// Shared types and codes of the min-tracking stack.
// ----------------------------------------------------------------------------
package minstk_pkg;

	localparam int DATA_W = 32;
	localparam int FILL_W = 11;

	localparam logic [1:0] REQ_PUSH = 2'd0;
	localparam logic [1:0] REQ_POP  = 2'd1;
	localparam logic [1:0] REQ_LOOK = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic latch;
		logic exec;
		logic load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic need_load;
	} dp_stat_t;

endpackage

@@ src/minstk_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// minstk_ctrl
// Controller that sequences one request through capture, execution,
// an optional top reload from the entry memory, and the result cycle.
// ----------------------------------------------------------------------------
module minstk_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  minstk_pkg::dp_stat_t  stat,
	output minstk_pkg::ctrl_cmd_t cmd,
	output logic                  busy,
	output logic                  done
);
	import minstk_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_LOAD = 2'd2;
	localparam logic [1:0] S_RESP = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = stat.need_load ? S_LOAD : S_RESP;
			end
			S_LOAD: begin
				state_d = S_RESP;
			end
			S_RESP: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign cmd.latch = (state_q == S_IDLE) && start;
	assign cmd.exec  = (state_q == S_EXEC);
	assign cmd.load  = (state_q == S_LOAD);
	assign busy      = (state_q != S_IDLE);
	assign done      = (state_q == S_RESP);

endmodule

@@ src/minstk_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// minstk_dp
// Datapath: entry memory of value and running minimum, entry count, and
// the top entry held in registers.
// ----------------------------------------------------------------------------
module minstk_dp #(
	parameter int STACK_DEPTH = 1024
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  minstk_pkg::ctrl_cmd_t                 cmd,
	output minstk_pkg::dp_stat_t                  stat,
	input  logic [1:0]                            req_type,
	input  logic signed [minstk_pkg::DATA_W-1:0]  push_value,
	output logic signed [minstk_pkg::DATA_W-1:0]  top_value,
	output logic signed [minstk_pkg::DATA_W-1:0]  min_value,
	output logic                                  is_empty,
	output logic [1:0]                            status,
	output logic [minstk_pkg::FILL_W-1:0]         fill_level
);
	import minstk_pkg::*;

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH);
	localparam int FW = (CW > FILL_W) ? CW : FILL_W;

	logic [1:0]               req_q;
	logic signed [DATA_W-1:0] val_q;
	logic [CW-1:0]            count_q;
	logic signed [DATA_W-1:0] top_val_q;
	logic signed [DATA_W-1:0] top_min_q;
	logic [1:0]               status_q;
	logic [2*DATA_W-1:0]      rd_q;
	logic [2*DATA_W-1:0]      mem [STACK_DEPTH];

	logic                     is_full;
	logic                     is_zero;
	logic signed [DATA_W-1:0] new_min;
	logic                     wr_en;
	logic [AW-1:0]            wr_addr;
	logic [CW-1:0]            rd_cnt;
	logic [FW-1:0]            count_ext;

	assign is_full  = (count_q == CW'(STACK_DEPTH));
	assign is_zero  = (count_q == '0);
	assign new_min  = (!is_zero && (top_min_q < val_q)) ? top_min_q : val_q;
	assign wr_en    = cmd.exec && (req_q == REQ_PUSH) && !is_full;
	assign wr_addr  = count_q[AW-1:0];
	assign rd_cnt   = count_q - CW'(2);

	assign stat.need_load = (req_q == REQ_POP) && (count_q > CW'(1));

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= {val_q, new_min};
		end
		rd_q <= mem[rd_cnt[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			req_q <= req_type;
			val_q <= push_value;
		end
		if (wr_en) begin
			top_val_q <= val_q;
			top_min_q <= new_min;
		end else if (cmd.load) begin
			top_val_q <= rd_q[2*DATA_W-1:DATA_W];
			top_min_q <= rd_q[DATA_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			status_q <= ST_OK;
		end else if (cmd.exec) begin
			status_q <= ST_OK;
			case (req_q)
				REQ_PUSH: begin
					if (is_full) begin
						status_q <= ST_FULL;
					end else begin
						count_q <= count_q + CW'(1);
					end
				end
				REQ_POP: begin
					if (is_zero) begin
						status_q <= ST_EMPTY;
					end else begin
						count_q <= count_q - CW'(1);
					end
				end
				default: begin
					status_q <= ST_OK;
				end
			endcase
		end
	end

	assign count_ext  = FW'(count_q);
	assign is_empty   = is_zero;
	assign top_value  = is_zero ? '1 : top_val_q;
	assign min_value  = is_zero ? '1 : top_min_q;
	assign status     = status_q;
	assign fill_level = count_ext[FILL_W-1:0];

endmodule

@@ src/min_tracking_stack.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_tracking_stack
// Stack of signed 32-bit words that reports the minimum of its contents.
// ----------------------------------------------------------------------------
// A request (push, pop or look) is taken when start is high and busy is low.
// Its result appears for exactly one cycle with done high, and the receiver
// cannot stall it. Push, look, an ignored pop and a pop that empties the
// stack pass through execution and the result state before the next request
// can be taken; a pop that leaves entries also passes a reload state, as the
// new top word is read from the entry memory through its registered read
// port. Top and minimum read as all ones when the stack is empty.
module min_tracking_stack #(
	parameter int STACK_DEPTH = 1024
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic [1:0]                            req_type,
	input  logic signed [minstk_pkg::DATA_W-1:0]  push_value,
	output logic                                  done,
	output logic signed [minstk_pkg::DATA_W-1:0]  top_value,
	output logic signed [minstk_pkg::DATA_W-1:0]  min_value,
	output logic                                  is_empty,
	output logic [1:0]                            status,
	output logic [minstk_pkg::FILL_W-1:0]         fill_level
);
	import minstk_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	minstk_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	minstk_dp #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.req_type   (req_type),
		.push_value (push_value),
		.top_value  (top_value),
		.min_value  (min_value),
		.is_empty   (is_empty),
		.status     (status),
		.fill_level (fill_level)
	);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted word did not raise busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe lasted more than one cycle");

	a_empty_reads: assert property (@(posedge clk) disable iff (!arst_n)
		(done && is_empty) |-> (top_value == '1 && min_value == '1))
		else $error("empty stack did not read all ones");

	a_min_order: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !is_empty) |-> (min_value <= top_value))
		else $error("minimum exceeds top word");

	a_full_level: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_FULL) |-> (fill_level == FILL_W'(STACK_DEPTH)))
		else $error("push dropped while stack not full");

endmodule
